// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBD_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/pbd_pkg.sv
package pbd_pkg;

  // Decoded bytes per output beat.
  localparam int OUT_LANES = 2;

  // Lanes in use per beat; a beat has only two byte fields.
  localparam int BEAT_LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 2) ? 2 : OUT_LANES);

  // Width of a run length; the longest run is 128 bytes.
  localparam int RUN_W = 8;

  // Depth of the command queue between the front and back ends.
  localparam int CMDQ_DEPTH = 2;

  // Header byte that is skipped.
  localparam logic [7:0] SKIP_HEADER = 8'h80;

  // Status codes carried on the last beat of a stream.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  // One input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [1:0] byte_count;
    logic       beat_last;
    logic       stream_end;
    logic [1:0] status;
  } out_t;

  // A classified command: emit count copies of value, then flag the end.
  typedef struct packed {
    logic [7:0]       value;
    logic [RUN_W-1:0] count;
    logic             stream_end;
    logic [1:0]       status;
  } cmd_t;

endpackage

// File: hw/rtl/pbd_front.sv
module pbd_front import pbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_REPEAT
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  logic [RUN_W-1:0] run_left;
  logic [RUN_W-1:0] run_left_next;
  logic [31:0]      bytes_out;
  logic             finished;
  logic [31:0]      output_limit;

  logic             accept;
  logic [RUN_W-1:0] n_raw;
  logic [RUN_W-1:0] n_clip;
  logic [31:0]      avail;
  logic             reached;
  logic             end_flag;
  logic [1:0]       status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the byte against the current phase.
  always_comb begin
    phase_next    = phase;
    run_left_next = run_left;
    n_raw         = '0;
    unique case (phase)
      PH_HEADER: begin
        if (in_data.in_byte == SKIP_HEADER) begin
          phase_next = PH_HEADER;
        end else if (in_data.in_byte[7]) begin
          phase_next    = PH_REPEAT;
          run_left_next = RUN_W'(9'd257 - {1'b0, in_data.in_byte});
        end else begin
          phase_next    = PH_LITERAL;
          run_left_next = RUN_W'({1'b0, in_data.in_byte} + 9'd1);
        end
      end
      PH_LITERAL: begin
        n_raw = RUN_W'(1);
        if (run_left != '0) begin
          run_left_next = run_left - RUN_W'(1);
        end
        if (run_left <= RUN_W'(1)) begin
          phase_next = PH_HEADER;
        end
      end
      PH_REPEAT: begin
        n_raw         = run_left;
        run_left_next = '0;
        phase_next    = PH_HEADER;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  // Clip against the output limit and work out the end status.
  always_comb begin
    avail   = (bytes_out < output_limit) ? (output_limit - bytes_out) : '0;
    reached = (output_limit != '0) && ({{(32-RUN_W){1'b0}}, n_raw} >= avail);
    n_clip  = reached ? avail[RUN_W-1:0] : n_raw;
    end_flag = reached || in_data.in_last;
    if (reached) begin
      status = ST_LIMIT;
    end else if (in_data.in_last && (phase_next != PH_HEADER)) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end
  end

  // Only commands that produce at least one beat enter the queue.
  assign q_push = accept && !finished && ((n_clip != '0) || end_flag);
  assign q_cmd  = '{value: in_data.in_byte, count: n_clip,
                    stream_end: end_flag, status: status};

  // Decoder state and the limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      run_left     <= '0;
      bytes_out    <= '0;
      finished     <= 1'b0;
      output_limit <= '0;
    end else begin
      if (cfg_wr_en) begin
        output_limit <= cfg_wr_data;
      end
      if (accept) begin
        if (in_data.in_last) begin
          phase     <= PH_HEADER;
          run_left  <= '0;
          bytes_out <= '0;
          finished  <= 1'b0;
        end else if (finished) begin
          finished <= 1'b1;
        end else if (reached) begin
          finished  <= 1'b1;
          phase     <= PH_HEADER;
          run_left  <= '0;
          bytes_out <= bytes_out + {{(32-RUN_W){1'b0}}, n_clip};
        end else begin
          phase     <= phase_next;
          run_left  <= run_left_next;
          bytes_out <= bytes_out + {{(32-RUN_W){1'b0}}, n_clip};
        end
      end
    end
  end

endmodule

// File: hw/rtl/pbd_cmd_fifo.sv
module pbd_cmd_fifo import pbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             entries [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(CMDQ_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  // Storage needs no reset; only pointers and fill do.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/pbd_back.sv
module pbd_back import pbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t q_head,
  input  logic q_empty,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [RUN_W-1:0] LANES_N = RUN_W'(BEAT_LANES);

  cmd_t             cur;
  logic             cur_active;
  cmd_t             src;
  logic             src_valid;
  logic             load;
  logic             fire;
  logic [RUN_W-1:0] beat_cnt;
  logic [RUN_W-1:0] left_after;
  logic             fin;
  out_t             beat;

  // Work on the held command, or straight from the queue head.
  assign src       = cur_active ? cur : q_head;
  assign src_valid = cur_active || !q_empty;
  assign load      = !out_valid || out_ready;
  assign fire      = load && src_valid;
  assign q_pop     = fire && !cur_active;

  // Size of this beat and what is left of the run after it.
  assign beat_cnt   = (src.count > LANES_N) ? LANES_N : src.count;
  assign left_after = src.count - beat_cnt;
  assign fin        = (left_after == '0);

  // Assemble the beat; unused lanes read as zero.
  always_comb begin
    beat.out_byte0  = (beat_cnt >= RUN_W'(1)) ? src.value : 8'd0;
    beat.out_byte1  = (beat_cnt >= RUN_W'(2)) ? src.value : 8'd0;
    beat.byte_count = beat_cnt[1:0];
    beat.beat_last  = fin;
    beat.stream_end = fin && src.stream_end;
    beat.status     = (fin && src.stream_end) ? src.status : ST_OK;
  end

  // Held command for runs longer than one beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_active <= 1'b0;
    end else if (fire) begin
      cur_active <= !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur <= '{value: src.value, count: left_after,
               stream_end: src.stream_end, status: src.status};
    end
  end

  // Output register: refills whenever it is empty or its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= beat;
    end
  end

endmodule

// File: hw/rtl/packbits_decoder.sv
// PackBits stream decoder. Compressed bytes arrive one per request on the
// input channel and decoded bytes leave in beats of up to two on the output
// channel. The front end takes one compressed byte per cycle while its
// two-entry command queue has room; a byte that yields data, or that ends a
// stream, becomes one command. The back end turns each command into
// ceil(n/2) beats (a single empty beat when n is zero), one per cycle while
// the output is not stalled, so a repeat of n bytes holds the back end for
// ceil(n/2) beats (64 for the longest run); input stalls only once the queue
// is full. When the back end is free, the output register takes the first
// beat of a byte at the clock edge after the one that accepts the byte.
// Write output_limit only while the block is idle; zero means no limit.
module packbits_decoder import pbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  // Header parsing, run tracking and limit clipping.
  pbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  // Command queue between the two halves.
  pbd_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_cmd),
    .pop       (q_pop),
    .pop_data  (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Beat expansion and output register.
  pbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/pbd_checker.sv
`include "assert_macros.svh"

module pbd_checker import pbd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic                 stalled;
  logic [$bits(out_t):0] shown;
  logic                 inner_beat;
  logic                 inner_ok;
  logic                 empty_beat;
  logic                 empty_ok;
  logic                 status_beat;
  logic                 status_ok;

  // What the output shows, and the conditions the assertions look at.
  assign stalled     = out_valid && !out_ready;
  assign shown       = {out_valid, out_data};
  assign inner_beat  = out_valid && !out_data.beat_last;
  assign inner_ok    = (out_data.byte_count == 2'(BEAT_LANES)) &&
                       !out_data.stream_end && (out_data.status == ST_OK);
  assign empty_beat  = out_valid && (out_data.byte_count == 2'd0);
  assign empty_ok    = out_data.beat_last && out_data.stream_end &&
                       (out_data.out_byte0 == 8'd0) && (out_data.out_byte1 == 8'd0);
  assign status_beat = out_valid && (out_data.status != ST_OK);
  assign status_ok   = out_data.stream_end &&
                       ((out_data.status == ST_TRUNC) || (out_data.status == ST_LIMIT));

  // A stalled beat stays valid and keeps its contents.
  `PBD_ASSERT_NEXT(a_out_hold, clk, rst, stalled, $stable(shown), "stalled beat changed")

  // Every beat except the last of a request is full and carries no end status.
  `PBD_ASSERT_NOW(a_mid_beat, clk, rst, inner_beat, inner_ok, "bad inner beat")

  // An empty beat only reports the end of a stream, with zero data.
  `PBD_ASSERT_NOW(a_empty_beat, clk, rst, empty_beat, empty_ok, "empty beat without stream end")

  // A nonzero status always comes with the end of a stream.
  `PBD_ASSERT_NOW(a_status_end, clk, rst, status_beat, status_ok, "bad status or no stream end")

endmodule

bind packbits_decoder pbd_checker u_pbd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
